@@ sv/iadc_pkg.sv @@
// ----------------------------------------------------------------------------
// iadc_pkg
// Shared types, codes and constants of the I2C ADC register model.
// ----------------------------------------------------------------------------
package iadc_pkg;

  // Field widths.
  localparam int unsigned PinW   = 23;
  localparam int unsigned AddrW  = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned NumW   = 40;
  localparam int unsigned QuotW  = 24;
  localparam int unsigned RecipW = 27;
  localparam int unsigned RecipShift = 33;

  // Bus event kinds.
  typedef enum logic [1:0] {
    ActConnect    = 2'd0,
    ActRead       = 2'd1,
    ActWrite      = 2'd2,
    ActDisconnect = 2'd3
  } action_e;

  // Register indexes.
  localparam logic [1:0] RegConversion = 2'd0;
  localparam logic [1:0] RegConfig     = 2'd1;
  localparam logic [1:0] RegLoThresh   = 2'd2;
  localparam logic [1:0] RegHiThresh   = 2'd3;

  // Write sequence stages; any stage from WsLsb upwards acts as WsLsb.
  localparam logic [1:0] WsPointer = 2'd0;
  localparam logic [1:0] WsMsb     = 2'd1;
  localparam logic [1:0] WsLsb     = 2'd2;

  // Reset values.
  localparam logic [AddrW-1:0] BusAddrReset = 7'h48;
  localparam logic [CodeW-1:0] ConvReset    = 16'h0000;
  localparam logic [CodeW-1:0] ConfigReset  = 16'h8583;
  localparam logic [CodeW-1:0] LoReset      = 16'h8000;
  localparam logic [CodeW-1:0] HiReset      = 16'h7FFF;
  localparam logic [CodeW-1:0] BusyFlag     = 16'h8000;
  localparam logic [CodeW:0]   CodeMax      = 17'd32767;

  // Reciprocals ceil(2^33 / c) for the odd part c of the full scale.
  localparam logic [RecipW-1:0] Recip125 = 27'd68719477;
  localparam logic [RecipW-1:0] Recip375 = 27'd22906493;

  // One accepted input word.
  typedef struct packed {
    logic [1:0]            action;
    logic [AddrW-1:0]      target_address;
    logic                  read_request;
    logic [ByteW-1:0]      write_byte;
    logic [3:0][PinW-1:0]  pins;
  } item_t;

  // Conversion request from the control logic.
  typedef struct packed {
    logic       start;
    logic [2:0] mux;
    logic [2:0] pga;
  } conv_req_t;

  // Conversion result, valid for one cycle.
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
  } conv_res_t;

  // Full scale in microvolts.
  function automatic logic [PinW-1:0] fs_uv(logic [2:0] pga);
    logic [PinW-1:0] fs;
    case (pga)
      3'd0:    fs = 23'd6144000;
      3'd1:    fs = 23'd4096000;
      3'd2:    fs = 23'd2048000;
      3'd3:    fs = 23'd1024000;
      3'd4:    fs = 23'd512000;
      default: fs = 23'd256000;
    endcase
    return fs;
  endfunction

  // Full scale is c * 2^s; this gives s + 1 (the extra bit halves the sum).
  function automatic logic [4:0] fs_shift(logic [2:0] pga);
    logic [4:0] sh;
    case (pga)
      3'd0:    sh = 5'd15;
      3'd1:    sh = 5'd16;
      3'd2:    sh = 5'd15;
      3'd3:    sh = 5'd14;
      3'd4:    sh = 5'd13;
      default: sh = 5'd12;
    endcase
    return sh;
  endfunction

endpackage

@@ sv/iadc_if.sv @@
// ----------------------------------------------------------------------------
// iadc_if
// Valid/ready channels of the I2C ADC register model.
// ----------------------------------------------------------------------------

// Bus event channel.
interface iadc_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  action;
  logic [iadc_pkg::AddrW-1:0]  target_address;
  logic                        read_request;
  logic [iadc_pkg::ByteW-1:0]  write_byte;
  logic [iadc_pkg::PinW-1:0]   ain0_microvolts;
  logic [iadc_pkg::PinW-1:0]   ain1_microvolts;
  logic [iadc_pkg::PinW-1:0]   ain2_microvolts;
  logic [iadc_pkg::PinW-1:0]   ain3_microvolts;

  modport source (
    output valid, action, target_address, read_request, write_byte,
           ain0_microvolts, ain1_microvolts, ain2_microvolts, ain3_microvolts,
    input  ready
  );
  modport sink (
    input  valid, action, target_address, read_request, write_byte,
           ain0_microvolts, ain1_microvolts, ain2_microvolts, ain3_microvolts,
    output ready
  );
endinterface

// Result channel.
interface iadc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        acknowledge;
  logic [iadc_pkg::ByteW-1:0]  read_byte;

  modport source (output valid, acknowledge, read_byte, input ready);
  modport sink (input valid, acknowledge, read_byte, output ready);
endinterface

// Configuration write channel.
interface iadc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [iadc_pkg::AddrW-1:0]  bus_address;

  modport source (output valid, bus_address, input ready);
  modport sink (input valid, bus_address, output ready);
endinterface

@@ sv/iadc_conv.sv @@
// ----------------------------------------------------------------------------
// iadc_conv
// Voltage to code conversion: clamp and scale in front of a stage register,
// reciprocal multiply, sign and saturation behind it.
// ----------------------------------------------------------------------------
module iadc_conv (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  iadc_pkg::conv_req_t                     req_i,
  input  logic [3:0][iadc_pkg::PinW-1:0]          pins_i,
  output iadc_pkg::conv_res_t                     res_o
);

  logic                         single;
  logic [iadc_pkg::PinW-1:0]    pos_pin;
  logic [iadc_pkg::PinW-1:0]    neg_pin;
  logic [iadc_pkg::PinW:0]      diff;
  logic [iadc_pkg::PinW:0]      diff_abs;
  logic [iadc_pkg::PinW-1:0]    fs;
  logic [iadc_pkg::PinW-1:0]    mag;
  logic [iadc_pkg::NumW-1:0]    mag_ext;
  logic [iadc_pkg::NumW-1:0]    num;
  logic [iadc_pkg::QuotW-1:0]   x_d;

  logic                         valid_q;
  logic                         neg_q;
  logic                         wide_q;
  logic [iadc_pkg::QuotW-1:0]   x_q;

  logic [iadc_pkg::RecipW-1:0]  recip;
  logic [iadc_pkg::QuotW+iadc_pkg::RecipW-1:0] prod;
  logic [iadc_pkg::CodeW:0]     quot;
  logic [iadc_pkg::CodeW:0]     quot_neg;

  // Input selection: the upper half of the mux codes is single-ended.
  always_comb begin
    single  = req_i.mux[2];
    pos_pin = pins_i[req_i.mux[1:0]];
    neg_pin = '0;
    case (req_i.mux)
      3'd0: begin
        pos_pin = pins_i[0];
        neg_pin = pins_i[1];
      end
      3'd1: begin
        pos_pin = pins_i[0];
        neg_pin = pins_i[3];
      end
      3'd2: begin
        pos_pin = pins_i[1];
        neg_pin = pins_i[3];
      end
      3'd3: begin
        pos_pin = pins_i[2];
        neg_pin = pins_i[3];
      end
      default: begin
        pos_pin = pins_i[req_i.mux[1:0]];
        neg_pin = '0;
      end
    endcase
  end

  // Clamp the magnitude to full scale and form 2*mag*K + FS, divided by the
  // power-of-two part of 2*FS. What remains is a division by 125 or 375.
  always_comb begin
    diff     = {1'b0, pos_pin} - {1'b0, neg_pin};
    diff_abs = diff[iadc_pkg::PinW] ? (~diff + 1'b1) : diff;
    fs       = iadc_pkg::fs_uv(req_i.pga);
    mag      = (diff_abs[iadc_pkg::PinW-1:0] > fs) ? fs : diff_abs[iadc_pkg::PinW-1:0];
    mag_ext  = iadc_pkg::NumW'(mag);
    num      = (mag_ext << 16) - (single ? (mag_ext << 1) : '0)
               + iadc_pkg::NumW'(fs);
    x_d      = iadc_pkg::QuotW'(num >> iadc_pkg::fs_shift(req_i.pga));
  end

  // Stage register between scaling and the reciprocal multiply.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= x_d;
      neg_q  <= diff[iadc_pkg::PinW];
      wide_q <= (req_i.pga == 3'd0);
    end
  end

  // Exact floor division by the odd factor, then sign and saturation.
  always_comb begin
    recip    = wide_q ? iadc_pkg::Recip375 : iadc_pkg::Recip125;
    prod     = (iadc_pkg::QuotW+iadc_pkg::RecipW)'(x_q)
               * (iadc_pkg::QuotW+iadc_pkg::RecipW)'(recip);
    quot     = prod[iadc_pkg::RecipShift +: (iadc_pkg::CodeW+1)];
    quot_neg = ~quot + 1'b1;
    res_o.valid = valid_q;
    if (neg_q) begin
      res_o.code = quot_neg[iadc_pkg::CodeW-1:0];
    end else if (quot > iadc_pkg::CodeMax) begin
      res_o.code = iadc_pkg::CodeMax[iadc_pkg::CodeW-1:0];
    end else begin
      res_o.code = quot[iadc_pkg::CodeW-1:0];
    end
  end

endmodule

@@ sv/i2c_adc_register_model.sv @@
// ----------------------------------------------------------------------------
// i2c_adc_register_model
// Register model of a four-input I2C ADC driven one bus event per word.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   in_if     sink       action, target_address, read_request, write_byte,
//                        ain0..ain3_microvolts
//   out_if    source     acknowledge, read_byte
//   cfg_if    sink       bus_address (always ready)
//
// One word is taken every cycle unless out_if.ready stalls; each word passes
// the input and result registers. A conversion ends in the cycle after its
// event via a reciprocal multiplier; a read in that cycle gets it forwarded.
// After reset the register file holds its reset values and the bus address
// is 0x48. When out_if.ready is low the result and one input word are held
// and in_if.ready falls.
module i2c_adc_register_model (
  input  logic            clk_i,
  input  logic            rst_ni,
  iadc_in_if.sink         in_if,
  iadc_out_if.source      out_if,
  iadc_cfg_if.sink        cfg_if
);

  iadc_pkg::item_t                  item_q;
  logic                             in_valid_q;
  logic                             out_valid_q;
  logic                             advance;
  logic                             load;

  logic [iadc_pkg::AddrW-1:0]       bus_addr_q;
  logic [3:0][iadc_pkg::CodeW-1:0]  rf_q;
  logic [3:0][iadc_pkg::CodeW-1:0]  rf_d;
  logic [1:0]                       ptr_q, ptr_d;
  logic                             bsel_q, bsel_d;
  logic [1:0]                       ws_q, ws_d;
  logic [iadc_pkg::ByteW-1:0]       held_q, held_d;

  logic                             ack_d;
  logic [iadc_pkg::ByteW-1:0]       rbyte_d;
  logic                             ack_q;
  logic [iadc_pkg::ByteW-1:0]       rbyte_q;

  logic                             rf_wr;
  logic [iadc_pkg::CodeW-1:0]       rf_wdata;
  logic [iadc_pkg::CodeW-1:0]       cfg_word;
  logic [iadc_pkg::CodeW-1:0]       reg_rd;

  iadc_pkg::conv_req_t              conv_req;
  iadc_pkg::conv_res_t              conv_res;

  // Handshake: the input register drains whenever the result register frees.
  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;
  assign load        = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input word register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.action         <= in_if.action;
      item_q.target_address <= in_if.target_address;
      item_q.read_request   <= in_if.read_request;
      item_q.write_byte     <= in_if.write_byte;
      item_q.pins[0]        <= in_if.ain0_microvolts;
      item_q.pins[1]        <= in_if.ain1_microvolts;
      item_q.pins[2]        <= in_if.ain2_microvolts;
      item_q.pins[3]        <= in_if.ain3_microvolts;
    end
  end

  // Bus address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_addr_q <= iadc_pkg::BusAddrReset;
    end else if (cfg_if.valid && cfg_if.ready) begin
      bus_addr_q <= cfg_if.bus_address;
    end
  end

  // Selected register, with a conversion still in flight forwarded.
  assign reg_rd = (ptr_q == iadc_pkg::RegConversion && conv_res.valid) ?
                  conv_res.code : rf_q[ptr_q];

  // Event decode and sequencing state.
  always_comb begin
    ack_d          = 1'b1;
    rbyte_d        = '0;
    ptr_d          = ptr_q;
    bsel_d         = bsel_q;
    ws_d           = ws_q;
    held_d         = held_q;
    rf_wr          = 1'b0;
    rf_wdata       = {held_q, item_q.write_byte};
    cfg_word       = rf_q[iadc_pkg::RegConfig];
    conv_req.start = 1'b0;
    if (advance) begin
      case (iadc_pkg::action_e'(item_q.action))
        iadc_pkg::ActConnect: begin
          if (item_q.target_address != bus_addr_q) begin
            ack_d = 1'b0;
          end else begin
            bsel_d = 1'b0;
            conv_req.start = item_q.read_request &&
                             (ptr_q == iadc_pkg::RegConversion);
          end
        end
        iadc_pkg::ActRead: begin
          rbyte_d = bsel_q ? reg_rd[7:0] : reg_rd[15:8];
          bsel_d  = ~bsel_q;
        end
        iadc_pkg::ActWrite: begin
          case (ws_q)
            iadc_pkg::WsPointer: begin
              ptr_d = item_q.write_byte[1:0];
              ws_d  = iadc_pkg::WsMsb;
            end
            iadc_pkg::WsMsb: begin
              held_d = item_q.write_byte;
              ws_d   = iadc_pkg::WsLsb;
            end
            default: begin
              rf_wr = 1'b1;
              ws_d  = iadc_pkg::WsPointer;
              if (ptr_q == iadc_pkg::RegConfig) begin
                cfg_word       = rf_wdata;
                conv_req.start = 1'b1;
              end
            end
          endcase
        end
        iadc_pkg::ActDisconnect: begin
          ws_d   = iadc_pkg::WsPointer;
          bsel_d = 1'b0;
        end
        default: begin
          ack_d = 1'b1;
        end
      endcase
    end
    conv_req.mux = cfg_word[14:12];
    conv_req.pga = cfg_word[11:9];
  end

  iadc_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (conv_req),
    .pins_i (item_q.pins),
    .res_o  (conv_res)
  );

  // Register file next values: a bus write outranks an older conversion.
  always_comb begin
    rf_d = rf_q;
    if (rf_wr && ptr_q == iadc_pkg::RegConversion) begin
      rf_d[iadc_pkg::RegConversion] = rf_wdata;
    end else if (conv_res.valid) begin
      rf_d[iadc_pkg::RegConversion] = conv_res.code;
    end
    if (conv_req.start) begin
      rf_d[iadc_pkg::RegConfig] = cfg_word | iadc_pkg::BusyFlag;
    end else if (rf_wr && ptr_q == iadc_pkg::RegConfig) begin
      rf_d[iadc_pkg::RegConfig] = rf_wdata;
    end
    if (rf_wr && ptr_q == iadc_pkg::RegLoThresh) begin
      rf_d[iadc_pkg::RegLoThresh] = rf_wdata;
    end
    if (rf_wr && ptr_q == iadc_pkg::RegHiThresh) begin
      rf_d[iadc_pkg::RegHiThresh] = rf_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q[iadc_pkg::RegConversion] <= iadc_pkg::ConvReset;
      rf_q[iadc_pkg::RegConfig]     <= iadc_pkg::ConfigReset;
      rf_q[iadc_pkg::RegLoThresh]   <= iadc_pkg::LoReset;
      rf_q[iadc_pkg::RegHiThresh]   <= iadc_pkg::HiReset;
      ptr_q  <= iadc_pkg::RegConversion;
      bsel_q <= 1'b0;
      ws_q   <= iadc_pkg::WsPointer;
      held_q <= '0;
    end else begin
      rf_q   <= rf_d;
      ptr_q  <= ptr_d;
      bsel_q <= bsel_d;
      ws_q   <= ws_d;
      held_q <= held_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      ack_q   <= ack_d;
      rbyte_q <= rbyte_d;
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.acknowledge = ack_q;
  assign out_if.read_byte   = rbyte_q;

  // A conversion result only follows an event that was processed.
  a_conv_follows_event: assert property (
    @(posedge clk_i) disable iff (!rst_ni) conv_res.valid |-> $past(advance)
  ) else $error("conversion result without a preceding event");

  // The write sequence never reaches the unused stage code.
  a_write_stage_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni) ws_q != 2'd3
  ) else $error("write stage out of range");

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_valid_q |-> in_if.ready
  ) else $error("input stalled with an empty result register");

  // A connect to another address leaves the byte select and starts nothing.
  a_wrong_address_quiet: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.action == iadc_pkg::ActConnect &&
     item_q.target_address != bus_addr_q)
    |=> ($stable(bsel_q) && !conv_res.valid)
  ) else $error("unmatched connect changed state");

  // A finishing conversion always sees its busy flag set.
  a_busy_flag_set: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    conv_res.valid |-> rf_q[iadc_pkg::RegConfig][15]
  ) else $error("conversion without config flag");

endmodule
